### rtl/srmv_pkg.sv
// Shared types, constants and saturation helper for the sparse row matrix-vector engine.
package srmv_pkg;

	localparam int MAX_ROWS    = 1024;
	localparam int MAX_ENTRIES = 2048;
	localparam int VECTOR_LEN  = 1024;

	localparam int ROW_AW   = $clog2(MAX_ROWS);
	localparam int ENT_AW   = $clog2(MAX_ENTRIES);
	localparam int VEC_AW   = $clog2(VECTOR_LEN);
	localparam int RCNT_W   = ROW_AW + 1;
	localparam int ECNT_W   = ENT_AW + 1;
	localparam int VCNT_W   = VEC_AW + 1;

	localparam int CFG_W    = 11;
	localparam int CFG_IW   = 2;

	typedef enum logic [1:0] {
		ACT_ADD     = 2'd0,
		ACT_LOAD    = 2'd1,
		ACT_COMPUTE = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_NUM_ROWS = 2'd0,
		REG_NUM_COLS = 2'd1,
		REG_IN_PLACE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [9:0]         row;
		logic [9:0]         column;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [9:0]         row_index;
		logic signed [31:0] sum;
		logic               last;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] v;
		logic               sat;
	} sat_res_t;

	localparam logic signed [48:0] Q_MAX = 49'sd2147483647;
	localparam logic signed [48:0] Q_MIN = -49'sd2147483648;

	// clip a wide sum into the Q16.16 word
	function automatic sat_res_t sat_q32(input logic signed [48:0] s);
		sat_res_t r;
		if (s > Q_MAX) begin
			r.v   = 32'sh7FFFFFFF;
			r.sat = 1'b1;
		end else if (s < Q_MIN) begin
			r.v   = 32'sh80000000;
			r.sat = 1'b1;
		end else begin
			r.v   = s[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

### rtl/srmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/srmv_mac.sv
// Shared multiply-accumulate unit: registered Q16.16 product, saturating accumulator.
module srmv_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic               mul_en,
	input  logic               acc_en,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] acc,
	output logic               sat
);

	logic signed [63:0] prod;
	logic signed [47:0] prod_s1;
	logic signed [31:0] acc_q;
	logic               sat_q;
	srmv_pkg::sat_res_t nxt;

	assign prod = a * b;
	// floor(p / 2^16) is the arithmetic shift
	assign nxt  = srmv_pkg::sat_q32({{17{acc_q[31]}}, acc_q} + {prod_s1[47], prod_s1});

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= prod[63:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (clr) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (acc_en) begin
			acc_q <= nxt.v;
			sat_q <= sat_q | nxt.sat;
		end
	end

	assign acc = acc_q;
	assign sat = sat_q;

endmodule

### rtl/sparse_row_matrix_vector_engine.sv
// Top level: sequencer, CSR stores, vector store and shared MAC of the sparse engine.
// Per beat: load_element and clear answer from the execute state; add_entry searches the
// entries already in the current row (column search, one RAM read per step);
// compute_next_row steps through each entry of the row (read, gather, multiply, add).
// One item at a time: in_ready is high only when idle with the output register empty.
// After reset the 1024-word vector store is zeroed word by word, with in_ready low;
// config writes are taken throughout.
module sparse_row_matrix_vector_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [srmv_pkg::CFG_IW-1:0]         cfg_idx,
	input  logic [srmv_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  srmv_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output srmv_pkg::out_item_t                 out_data
);

	localparam int RA = srmv_pkg::ROW_AW;
	localparam int EA = srmv_pkg::ENT_AW;
	localparam int VA = srmv_pkg::VEC_AW;

	// sequencer states, one-hot
	typedef enum logic [10:0] {
		S_CLR     = 11'b00000000001,
		S_IDLE    = 11'b00000000010,
		S_EXEC    = 11'b00000000100,
		S_ADD_RD  = 11'b00000001000,
		S_ADD_CMP = 11'b00000010000,
		S_RS0     = 11'b00000100000,
		S_RS1     = 11'b00001000000,
		S_E0      = 11'b00010000000,
		S_E1      = 11'b00100000000,
		S_E2      = 11'b01000000000,
		S_E3      = 11'b10000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [srmv_pkg::CFG_W-1:0] num_rows_q, num_cols_q;
	logic                       in_place_q;

	// matrix bookkeeping
	logic [srmv_pkg::RCNT_W-1:0] row_count_q;
	logic [srmv_pkg::ECNT_W-1:0] entry_count_q;
	logic [RA-1:0]               cursor_q;
	logic [9:0]                  last_label_q;   // label of the newest row record
	logic [srmv_pkg::ECNT_W-1:0] cur_start_q;    // start of the newest row record

	// per-item working registers
	srmv_pkg::in_item_t          item_q;
	logic [srmv_pkg::ECNT_W-1:0] idx_q;
	logic [srmv_pkg::ECNT_W-1:0] end_q;
	logic [RA-1:0]               r_q;
	logic [9:0]                  label_q;
	logic signed [31:0]          val_q;
	logic [srmv_pkg::VCNT_W-1:0] clr_idx_q;

	// output register
	logic                 out_valid_q;
	srmv_pkg::out_item_t  out_q;

	// RAM ports
	logic          rl_we;
	logic [9:0]    rl_rdata;
	logic          rs_we;
	logic [RA-1:0] rs_raddr;
	logic [srmv_pkg::ECNT_W-1:0] rs_rdata;
	logic          ec_we;
	logic [9:0]    ec_rdata;
	logic          ev_we;
	logic [31:0]   ev_wdata, ev_rdata;
	logic [EA-1:0] ev_waddr;
	logic          vs_we;
	logic [VA-1:0] vs_waddr;
	logic [31:0]   vs_wdata, vs_rdata;

	// MAC
	logic               mac_clr, mac_mul, mac_acc, mac_sat;
	logic signed [31:0] mac_sum;

	logic accept;
	logic new_row, range_bad, col_match, last_row;
	srmv_pkg::sat_res_t merge;
	logic [RA:0] r_next;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;

	assign range_bad = ({1'b0, item_q.row} >= num_rows_q) ||
		({1'b0, item_q.column} >= num_cols_q);
	assign new_row   = (row_count_q == '0) || (last_label_q != item_q.row);
	assign col_match = (ec_rdata == item_q.column);
	assign merge     = srmv_pkg::sat_q32({{17{ev_rdata[31]}}, ev_rdata} +
		{{17{item_q.value[31]}}, item_q.value});
	assign r_next    = {1'b0, r_q} + 1'b1;
	assign last_row  = (r_next == row_count_q);

	// row start of the record in EXEC, start of the following record after that
	assign rs_raddr = (state_q == S_EXEC) ? r_q : r_next[RA-1:0];

	// write port steering
	always_comb begin
		rl_we    = 1'b0;
		rs_we    = 1'b0;
		ec_we    = 1'b0;
		ev_we    = 1'b0;
		ev_waddr = entry_count_q[EA-1:0];
		ev_wdata = item_q.value;
		vs_we    = 1'b0;
		vs_waddr = item_q.column;
		vs_wdata = item_q.value;
		mac_mul  = 1'b0;
		mac_acc  = 1'b0;
		case (state_q)
			S_CLR: begin
				vs_we    = 1'b1;
				vs_waddr = clr_idx_q[VA-1:0];
				vs_wdata = '0;
			end
			S_EXEC: begin
				if (item_q.action == srmv_pkg::ACT_LOAD) begin
					vs_we = ({1'b0, item_q.column} < num_cols_q);
				end
				if (item_q.action == srmv_pkg::ACT_ADD && !range_bad && new_row &&
						row_count_q < srmv_pkg::RCNT_W'(srmv_pkg::MAX_ROWS) &&
						entry_count_q < srmv_pkg::ECNT_W'(srmv_pkg::MAX_ENTRIES)) begin
					rl_we = 1'b1;
					rs_we = 1'b1;
				end
			end
			S_ADD_RD: begin
				if (idx_q == entry_count_q &&
						entry_count_q < srmv_pkg::ECNT_W'(srmv_pkg::MAX_ENTRIES)) begin
					ec_we = 1'b1;
					ev_we = 1'b1;
				end
			end
			S_ADD_CMP: begin
				if (col_match) begin
					ev_we    = 1'b1;
					ev_waddr = idx_q[EA-1:0];
					ev_wdata = merge.v;
				end
			end
			S_E0: begin
				if (idx_q == end_q && in_place_q) begin
					vs_we    = 1'b1;
					vs_waddr = label_q;
					vs_wdata = mac_sum;
				end
			end
			S_E2: mac_mul = 1'b1;
			S_E3: mac_acc = 1'b1;
			default: ;
		endcase
	end

	assign mac_clr = accept;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (state_q == S_E1) begin
			val_q <= ev_rdata;
		end
		if (state_q == S_RS1) begin
			label_q <= rl_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			num_rows_q    <= srmv_pkg::CFG_W'(1024);
			num_cols_q    <= srmv_pkg::CFG_W'(1024);
			in_place_q    <= 1'b0;
			row_count_q   <= '0;
			entry_count_q <= '0;
			cursor_q      <= '0;
			last_label_q  <= '0;
			cur_start_q   <= '0;
			idx_q         <= '0;
			end_q         <= '0;
			r_q           <= '0;
			clr_idx_q     <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					srmv_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data;
					srmv_pkg::REG_NUM_COLS: num_cols_q <= cfg_data;
					srmv_pkg::REG_IN_PLACE: in_place_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == srmv_pkg::VCNT_W'(srmv_pkg::VECTOR_LEN - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						// output register is empty here, so its fields start from zero
						out_q   <= '0;
						state_q <= S_EXEC;
						r_q     <= ({1'b0, cursor_q} >= row_count_q) ? '0 : cursor_q;
					end
				end
				S_EXEC: begin
					case (item_q.action)
						srmv_pkg::ACT_ADD: begin
							if (range_bad) begin
								out_q.status <= srmv_pkg::STAT_RANGE;
								out_valid_q  <= 1'b1;
								state_q      <= S_IDLE;
							end else if (new_row) begin
								if (row_count_q >= srmv_pkg::RCNT_W'(srmv_pkg::MAX_ROWS) ||
										entry_count_q >=
										srmv_pkg::ECNT_W'(srmv_pkg::MAX_ENTRIES)) begin
									out_q.status <= srmv_pkg::STAT_FULL;
									out_valid_q  <= 1'b1;
									state_q      <= S_IDLE;
								end else begin
									row_count_q  <= row_count_q + 1'b1;
									last_label_q <= item_q.row;
									cur_start_q  <= entry_count_q;
									idx_q        <= entry_count_q;
									state_q      <= S_ADD_RD;
								end
							end else begin
								idx_q   <= cur_start_q;
								state_q <= S_ADD_RD;
							end
						end
						srmv_pkg::ACT_LOAD: begin
							out_q.status <= ({1'b0, item_q.column} < num_cols_q) ?
								srmv_pkg::STAT_OK : srmv_pkg::STAT_RANGE;
							out_valid_q  <= 1'b1;
							state_q      <= S_IDLE;
						end
						srmv_pkg::ACT_COMPUTE: begin
							if (row_count_q == '0) begin
								out_q.status <= srmv_pkg::STAT_EMPTY;
								out_valid_q  <= 1'b1;
								state_q      <= S_IDLE;
							end else begin
								state_q <= S_RS0;
							end
						end
						default: begin
							row_count_q   <= '0;
							entry_count_q <= '0;
							cursor_q      <= '0;
							out_q.status  <= srmv_pkg::STAT_OK;
							out_valid_q   <= 1'b1;
							state_q       <= S_IDLE;
						end
					endcase
				end
				S_ADD_RD: begin
					if (idx_q == entry_count_q) begin
						if (entry_count_q < srmv_pkg::ECNT_W'(srmv_pkg::MAX_ENTRIES)) begin
							entry_count_q <= entry_count_q + 1'b1;
							out_q.status  <= srmv_pkg::STAT_OK;
						end else begin
							out_q.status  <= srmv_pkg::STAT_FULL;
						end
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_ADD_CMP;
					end
				end
				S_ADD_CMP: begin
					if (col_match) begin
						out_q.status    <= srmv_pkg::STAT_OK;
						out_q.saturated <= merge.sat;
						out_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_ADD_RD;
					end
				end
				S_RS0: begin
					// first entry of the record now on rs_rdata, next start requested
					idx_q   <= rs_rdata;
					state_q <= S_RS1;
				end
				S_RS1: state_q <= S_E0;
				S_E0: begin
					if (idx_q == end_q) begin
						out_q.status    <= srmv_pkg::STAT_OK;
						out_q.row_index <= label_q;
						out_q.sum       <= mac_sum;
						out_q.last      <= last_row;
						out_q.saturated <= mac_sat;
						out_valid_q     <= 1'b1;
						cursor_q        <= last_row ? '0 : r_next[RA-1:0];
						state_q         <= S_IDLE;
					end else begin
						state_q <= S_E1;
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: state_q <= S_E3;
				S_E3: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_E0;
				end
				default: state_q <= S_IDLE;
			endcase
			// row end: next row's start, or the entry count for the final row
			if (state_q == S_RS1) begin
				end_q <= last_row ? entry_count_q : rs_rdata;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	srmv_ram #(.WIDTH(10), .DEPTH(srmv_pkg::MAX_ROWS)) u_row_label (
		.clk   (clk),
		.we    (rl_we),
		.waddr (row_count_q[RA-1:0]),
		.wdata (item_q.row),
		.raddr (r_q),
		.rdata (rl_rdata)
	);

	srmv_ram #(.WIDTH(srmv_pkg::ECNT_W), .DEPTH(srmv_pkg::MAX_ROWS)) u_row_start (
		.clk   (clk),
		.we    (rs_we),
		.waddr (row_count_q[RA-1:0]),
		.wdata (entry_count_q),
		.raddr (rs_raddr),
		.rdata (rs_rdata)
	);

	srmv_ram #(.WIDTH(10), .DEPTH(srmv_pkg::MAX_ENTRIES)) u_entry_column (
		.clk   (clk),
		.we    (ec_we),
		.waddr (entry_count_q[EA-1:0]),
		.wdata (item_q.column),
		.raddr (idx_q[EA-1:0]),
		.rdata (ec_rdata)
	);

	srmv_ram #(.WIDTH(32), .DEPTH(srmv_pkg::MAX_ENTRIES)) u_entry_value (
		.clk   (clk),
		.we    (ev_we),
		.waddr (ev_waddr),
		.wdata (ev_wdata),
		.raddr (idx_q[EA-1:0]),
		.rdata (ev_rdata)
	);

	srmv_ram #(.WIDTH(32), .DEPTH(srmv_pkg::VECTOR_LEN)) u_vector (
		.clk   (clk),
		.we    (vs_we),
		.waddr (vs_waddr),
		.wdata (vs_wdata),
		.raddr (ec_rdata[VA-1:0]),
		.rdata (vs_rdata)
	);

	srmv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mac_clr),
		.mul_en (mac_mul),
		.acc_en (mac_acc),
		.a      (val_q),
		.b      (vs_rdata),
		.acc    (mac_sum),
		.sat    (mac_sat)
	);

endmodule
